@@ hw/rtl/fur_pkg.sv @@
package fur_pkg;

    // Input item: one link event.
    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } t_in;

    // Result item: one host byte, erase, program or restart request.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  host_byte;
        logic [2:0]  sector_index;
        logic        bank_select;
        logic [31:0] flash_address;
        logic [7:0]  flash_data;
        logic        last;
    } t_out;

    // Result kinds.
    localparam logic [1:0] KIND_HOST    = 2'd0;
    localparam logic [1:0] KIND_ERASE   = 2'd1;
    localparam logic [1:0] KIND_PROG    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    // Input actions.
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Bytes sent to the host.
    localparam logic [7:0] HOST_ACK          = 8'h55;
    localparam logic [7:0] HOST_SUCCESS      = 8'hAA;
    localparam logic [7:0] HOST_BAD_CMD      = 8'hFF;
    localparam logic [7:0] HOST_SIZE_TIMEOUT = 8'h01;
    localparam logic [7:0] HOST_SIZE_ERROR   = 8'h02;
    localparam logic [7:0] HOST_DATA_TIMEOUT = 8'h03;
    localparam logic [7:0] HOST_CRC_TIMEOUT  = 8'h05;
    localparam logic [7:0] HOST_CRC_ERROR    = 8'h06;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_IMAGE  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_BASE = 2'd1;
    localparam logic [1:0] CFG_BANK_SPLIT = 2'd2;

    // Configuration reset values.
    localparam logic [20:0] RST_MAX_IMAGE  = 21'd1835008;
    localparam logic [31:0] RST_IMAGE_BASE = 32'h0802_0400;
    localparam logic [31:0] RST_BANK_SPLIT = 32'h0810_0000;

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Hardest erase count the sequence ever issues.
    localparam int ERASE_LIMIT = 14;

    // Command word "UPDT", one byte per position.
    function automatic logic [7:0] cmd_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = 8'h55;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h44;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    // One byte step of the reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       out_load;
        logic [1:0] out_kind;
        logic [7:0] host_code;
        logic       out_last;
        logic [1:0] byte_pos;
        logic       size_clear;
        logic       size_take;
        logic       data_start;
        logic       data_take;
        logic       crc_clear;
        logic       crc_take;
        logic       erase_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic cmd_hit;
        logic size_bad;
        logic last_data;
        logic crc_ok;
        logic erase_more;
    } t_stat;

endpackage

@@ hw/rtl/fur_dp.sv @@
module fur_dp #(
    parameter int SECTOR_BYTES     = 131072,
    parameter int SECTORS_PER_BANK = 8,
    parameter int MAX_SECTORS      = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fur_pkg::t_cmd       i_cmd,
    input  logic [7:0]          i_byte,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_out_ready,
    output fur_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    output fur_pkg::t_out       o_out
);

    localparam logic [31:0] SIZE_LIMIT = 32'(MAX_SECTORS * SECTOR_BYTES);
    localparam logic [31:0] SECT_STEP  = 32'(SECTOR_BYTES);
    localparam logic [4:0]  ERASE_CAP  =
        5'((MAX_SECTORS < fur_pkg::ERASE_LIMIT) ? MAX_SECTORS : fur_pkg::ERASE_LIMIT);
    localparam logic [4:0]  BANK_SECTS = 5'(SECTORS_PER_BANK);

    logic [20:0]   r_max_image;
    logic [31:0]   r_image_base;
    logic [31:0]   r_bank_split;
    logic [31:0]   r_size;
    logic [20:0]   r_count;
    logic [31:0]   r_addr;
    logic [31:0]   r_crc;
    logic [31:0]   r_exp;
    logic [3:0]    r_sec;
    logic [31:0]   r_off;
    logic          r_out_valid;
    fur_pkg::t_out r_out;

    logic [31:0]   size_next;
    logic [31:0]   exp_next;
    logic [20:0]   count_next;
    logic [4:0]    sec_ext;
    logic [4:0]    sec_in_bank;
    logic          slot_free;
    fur_pkg::t_out n_out;

    // Field assembly, little-endian, one byte per position.
    assign size_next  = r_size | ({24'd0, i_byte} << {i_cmd.byte_pos, 3'd0});
    assign exp_next   = r_exp  | ({24'd0, i_byte} << {i_cmd.byte_pos, 3'd0});
    assign count_next = r_count + 21'd1;
    assign sec_ext    = {1'b0, r_sec};
    assign sec_in_bank = (sec_ext < BANK_SECTS) ? sec_ext : (sec_ext - BANK_SECTS);
    assign slot_free  = !r_out_valid || i_out_ready;

    // Status toward the controller. A size is rejected when it is zero or
    // exceeds either the configured maximum or the sector capacity.
    always_comb begin
        o_stat.slot_free  = slot_free;
        o_stat.cmd_hit    = (i_byte == fur_pkg::cmd_byte(i_cmd.byte_pos));
        o_stat.size_bad   = (size_next == 32'd0) ||
                            (size_next > {11'd0, r_max_image}) || (size_next > SIZE_LIMIT);
        o_stat.last_data  = ({11'd0, count_next} >= r_size);
        o_stat.crc_ok     = ((r_crc ^ fur_pkg::CRC_INIT) == exp_next);
        o_stat.erase_more = ((sec_ext + 5'd1) <= ERASE_CAP) && ((r_off + SECT_STEP) < r_size);
    end

    // Result formatting for the output register.
    always_comb begin
        n_out = '0;
        n_out.kind = i_cmd.out_kind;
        n_out.last = i_cmd.out_last;
        case (i_cmd.out_kind)
            fur_pkg::KIND_HOST: begin
                n_out.host_byte = i_cmd.host_code;
            end
            fur_pkg::KIND_ERASE: begin
                n_out.sector_index = sec_in_bank[2:0];
                n_out.bank_select  = (sec_ext >= BANK_SECTS);
            end
            fur_pkg::KIND_PROG: begin
                n_out.bank_select   = (r_addr >= r_bank_split);
                n_out.flash_address = r_addr;
                n_out.flash_data    = i_byte;
            end
            default: begin
                n_out.kind = fur_pkg::KIND_RESTART;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_image  <= fur_pkg::RST_MAX_IMAGE;
            r_image_base <= fur_pkg::RST_IMAGE_BASE;
            r_bank_split <= fur_pkg::RST_BANK_SPLIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fur_pkg::CFG_MAX_IMAGE:  r_max_image  <= i_cfg_wdata[20:0];
                fur_pkg::CFG_IMAGE_BASE: r_image_base <= i_cfg_wdata;
                fur_pkg::CFG_BANK_SPLIT: r_bank_split <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Image size, data counters, CRC and erase walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_count <= '0;
            r_addr  <= '0;
            r_crc   <= fur_pkg::CRC_INIT;
            r_exp   <= '0;
            r_sec   <= 4'd1;
            r_off   <= '0;
        end else begin
            if (i_cmd.size_clear) begin
                r_size <= '0;
            end else if (i_cmd.size_take) begin
                r_size <= size_next;
            end
            if (i_cmd.data_start) begin
                r_count <= '0;
                r_addr  <= r_image_base;
                r_crc   <= fur_pkg::CRC_INIT;
                r_sec   <= 4'd1;
                r_off   <= '0;
            end else if (i_cmd.data_take) begin
                r_count <= count_next;
                r_addr  <= r_addr + 32'd1;
                r_crc   <= fur_pkg::crc_byte(r_crc, i_byte);
            end else if (i_cmd.erase_step) begin
                r_sec <= r_sec + 4'd1;
                r_off <= r_off + SECT_STEP;
            end
            if (i_cmd.crc_clear) begin
                r_exp <= '0;
            end else if (i_cmd.crc_take) begin
                r_exp <= exp_next;
            end
        end
    end

    // Output register: holds one result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hw/rtl/fur_ctrl.sv @@
module fur_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    input  fur_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output fur_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_CMD,
        ST_SIZE,
        ST_DATA,
        ST_CRC,
        ST_ERASE,
        ST_SECOND
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_fcount, n_fcount;
    logic       r_match, n_match;
    logic       r_restart, n_restart;
    logic       accept;
    logic       timeout;
    logic       match_next;

    // Inputs are taken only in the four phase states, with room for a result.
    always_comb begin
        case (r_state)
            ST_CMD, ST_SIZE, ST_DATA, ST_CRC: o_in_ready = i_stat.slot_free;
            default:                          o_in_ready = 1'b0;
        endcase
    end

    assign accept     = i_in_valid && o_in_ready;
    assign timeout    = (i_action == fur_pkg::ACT_TIMEOUT);
    assign match_next = r_match && i_stat.cmd_hit;

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_fcount  = r_fcount;
        n_match   = r_match;
        n_restart = r_restart;
        o_cmd     = '0;
        o_cmd.byte_pos = r_fcount;

        unique case (r_state)
            ST_CMD: begin
                if (accept) begin
                    if (timeout) begin
                        n_fcount = 2'd0;
                        n_match  = 1'b1;
                    end else if (r_fcount == 2'd3) begin
                        n_fcount = 2'd0;
                        n_match  = 1'b1;
                        if (match_next) begin
                            n_state          = ST_SIZE;
                            o_cmd.size_clear = 1'b1;
                        end else begin
                            o_cmd.out_load  = 1'b1;
                            o_cmd.out_kind  = fur_pkg::KIND_HOST;
                            o_cmd.host_code = fur_pkg::HOST_BAD_CMD;
                            o_cmd.out_last  = 1'b1;
                        end
                    end else begin
                        n_fcount = r_fcount + 2'd1;
                        n_match  = match_next;
                    end
                end
            end

            ST_SIZE: begin
                if (accept) begin
                    if (timeout) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_kind  = fur_pkg::KIND_HOST;
                        o_cmd.host_code = fur_pkg::HOST_SIZE_TIMEOUT;
                        o_cmd.out_last  = 1'b1;
                        n_state  = ST_CMD;
                        n_fcount = 2'd0;
                        n_match  = 1'b1;
                    end else begin
                        o_cmd.size_take = 1'b1;
                        if (r_fcount == 2'd3) begin
                            // The acknowledge is always followed by more results.
                            o_cmd.out_load  = 1'b1;
                            o_cmd.out_kind  = fur_pkg::KIND_HOST;
                            o_cmd.host_code = fur_pkg::HOST_ACK;
                            n_fcount = 2'd0;
                            if (i_stat.size_bad) begin
                                n_state   = ST_SECOND;
                                n_restart = 1'b0;
                                n_match   = 1'b1;
                            end else begin
                                n_state          = ST_ERASE;
                                o_cmd.data_start = 1'b1;
                            end
                        end else begin
                            n_fcount = r_fcount + 2'd1;
                        end
                    end
                end
            end

            ST_ERASE: begin
                if (i_stat.slot_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = fur_pkg::KIND_ERASE;
                    o_cmd.out_last   = !i_stat.erase_more;
                    o_cmd.erase_step = 1'b1;
                    if (!i_stat.erase_more) begin
                        n_state = ST_DATA;
                    end
                end
            end

            ST_DATA: begin
                if (accept) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    if (timeout) begin
                        o_cmd.out_kind  = fur_pkg::KIND_HOST;
                        o_cmd.host_code = fur_pkg::HOST_DATA_TIMEOUT;
                        n_state  = ST_CMD;
                        n_fcount = 2'd0;
                        n_match  = 1'b1;
                    end else begin
                        o_cmd.out_kind  = fur_pkg::KIND_PROG;
                        o_cmd.data_take = 1'b1;
                        if (i_stat.last_data) begin
                            n_state         = ST_CRC;
                            n_fcount        = 2'd0;
                            o_cmd.crc_clear = 1'b1;
                        end
                    end
                end
            end

            ST_CRC: begin
                if (accept) begin
                    if (timeout) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_kind  = fur_pkg::KIND_HOST;
                        o_cmd.host_code = fur_pkg::HOST_CRC_TIMEOUT;
                        o_cmd.out_last  = 1'b1;
                        n_state  = ST_CMD;
                        n_fcount = 2'd0;
                        n_match  = 1'b1;
                    end else begin
                        o_cmd.crc_take = 1'b1;
                        if (r_fcount == 2'd3) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_kind = fur_pkg::KIND_HOST;
                            n_fcount = 2'd0;
                            n_match  = 1'b1;
                            if (i_stat.crc_ok) begin
                                o_cmd.host_code = fur_pkg::HOST_SUCCESS;
                                n_state   = ST_SECOND;
                                n_restart = 1'b1;
                            end else begin
                                o_cmd.host_code = fur_pkg::HOST_CRC_ERROR;
                                o_cmd.out_last  = 1'b1;
                                n_state = ST_CMD;
                            end
                        end else begin
                            n_fcount = r_fcount + 2'd1;
                        end
                    end
                end
            end

            ST_SECOND: begin
                // Closing result: restart request or the size error code.
                if (i_stat.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    if (r_restart) begin
                        o_cmd.out_kind = fur_pkg::KIND_RESTART;
                    end else begin
                        o_cmd.out_kind  = fur_pkg::KIND_HOST;
                        o_cmd.host_code = fur_pkg::HOST_SIZE_ERROR;
                    end
                    n_state = ST_CMD;
                end
            end

            default: begin
                n_state  = ST_CMD;
                n_fcount = 2'd0;
                n_match  = 1'b1;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CMD;
            r_fcount  <= 2'd0;
            r_match   <= 1'b1;
            r_restart <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fcount  <= n_fcount;
            r_match   <= n_match;
            r_restart <= n_restart;
        end
    end

endmodule

@@ hw/rtl/firmware_update_receiver.sv @@
// Firmware update receiver.
// The input channel (i_in_valid, o_in_ready, i_in) carries one link event per
// item: a host byte or a read timeout. The output channel (o_out_valid,
// i_out_ready, o_out) carries host replies, sector erase requests, flash
// program requests and a restart request; the last result of an item has
// its last flag set. Configuration is written through i_cfg_we, i_cfg_index
// and i_cfg_wdata; the user must write it only while the block is idle, which
// the block does not enforce. A result caused by an item appears in the cycle
// after the item is taken. An item that causes at most one result leaves the
// block ready for the next, so a new item can be taken every cycle while the
// receiver keeps up. A valid image size causes the acknowledge and then one
// erase per cycle while the receiver keeps up, up to 14, during which no item
// is taken; the datapath's erase walk sets this figure. A successful CRC check
// or a rejected size gives two results, one after the other. Reset returns the
// block to waiting for a command and restores the configuration registers to
// their defaults. When the receiver stalls, the pending result holds in the
// output register and no item is taken until there is room for the next one.
module firmware_update_receiver #(
    parameter int SECTOR_BYTES     = 131072,
    parameter int SECTORS_PER_BANK = 8,
    parameter int MAX_SECTORS      = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fur_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fur_pkg::t_out  o_out,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_wdata
);

    fur_pkg::t_cmd  cmd;
    fur_pkg::t_stat stat;

    // Sequencer for the command, size, erase, data and CRC phases.
    fur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in.action),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Counters, CRC, configuration and the output register.
    fur_dp #(
        .SECTOR_BYTES     (SECTOR_BYTES),
        .SECTORS_PER_BANK (SECTORS_PER_BANK),
        .MAX_SECTORS      (MAX_SECTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_byte      (i_in.byte_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
